>>> hdl/sld_pkg.sv
// shared types and constants for the sorted list insert/delete block
package sld_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 8;
   localparam int POS_W        = 4;
   localparam int COUNT_W      = 5;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_DELETE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   // outcome of one entry-versus-value compare
   typedef struct packed {
      logic ge;
      logic eq;
   } cmp_res_type;

endpackage

>>> hdl/sld_req_if.sv
// command channel: kind and value with valid/ready handshake
interface sld_req_if;
   logic                        valid;
   logic                        ready;
   sld_pkg::kind_type           kind;
   logic [sld_pkg::VALUE_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink (input valid, input kind, input value, output ready);
endinterface

>>> hdl/sld_rsp_if.sv
// result channel: status, position, count, empty flag and smallest value
interface sld_rsp_if;
   logic                        valid;
   logic                        ready;
   sld_pkg::status_type         status;
   logic [sld_pkg::POS_W-1:0]   position;
   logic [sld_pkg::COUNT_W-1:0] entry_count;
   logic                        is_empty;
   logic [sld_pkg::VALUE_W-1:0] smallest_value;

   modport source (output valid, output status, output position, output entry_count,
                   output is_empty, output smallest_value, input ready);
   modport sink (input valid, input status, input position, input entry_count,
                 input is_empty, input smallest_value, output ready);
endinterface

>>> hdl/sld_ram.sv
// generic simple dual-port ram with registered read
module sld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/sld_cmp.sv
// shared byte comparator used by the scan
module sld_cmp (
   input  logic [sld_pkg::VALUE_W-1:0] entry,
   input  logic [sld_pkg::VALUE_W-1:0] value,
   output sld_pkg::cmp_res_type        res
);
   import sld_pkg::*;

   // unsigned compare
   assign res.ge = (entry >= value);
   assign res.eq = (entry == value);
endmodule

>>> hdl/sorted_list_insert_delete.sv
// sorted list insert/delete: bounded ascending multiset of bytes in a ram
//
// usage
//  - req_if carries one command word: kind (insert or delete) and an unsigned
//    byte value; it is taken when valid and ready are both high
//  - rsp_if returns exactly one word per command: status, position touched,
//    entry count, empty flag and the smallest stored value
//  - ready is high only while the sequencer is idle; one command at a time
// timing
//  - a linear scan reads one ram entry per cycle through the single read port
//    and compares it in the shared comparator, then a shift pass moves the
//    tail one entry per cycle over the same port; an insert then writes its
//    value into the freed slot, and last entry 0 is re-read; a full insert
//    skips the scan and shift, a delete with no match skips the shift; ready
//    returns high in the same cycle that the result first shows on rsp_if
// stalls and reset
//  - the result sits in an output register; a new command is accepted while
//    it waits, and the next result holds in the final state until taken
//  - reset empties the list (count to zero) and drops any pending result;
//    the ram contents are not cleared and no clearing pass is needed
module sorted_list_insert_delete #(
   parameter int CAPACITY = sld_pkg::CAPACITY_DEF
) (
   input  logic      clock,
   input  logic      reset,
   sld_req_if.sink   req_if,
   sld_rsp_if.source rsp_if
);
   import sld_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_SHIFT = 6'b000100,
      S_PUT   = 6'b001000,
      S_HEAD  = 6'b010000,
      S_WAIT  = 6'b100000
   } state_type;

   // control state
   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic                 rsp_valid_ff;

   // command and result payload
   kind_type             kind_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [AW-1:0]        wa_ff, wa_in;
   status_type           status_ff, status_in;
   status_type           rsp_status_ff;
   logic [POS_W-1:0]     rsp_position_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_empty_ff;
   logic [VALUE_W-1:0]   rsp_smallest_ff;

   // ram port
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [VALUE_W-1:0]   ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [VALUE_W-1:0]   ram_rd_data;

   cmp_res_type          cmp_res;
   logic                 hit;
   logic                 accept;
   logic                 rsp_load;
   logic [CW-1:0]        idx_dec;
   logic [CW+POS_W-1:0]  pos_wide;
   logic [CW+COUNT_W-1:0] count_wide;

   sld_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sld_cmp u_cmp (
      .entry (ram_rd_data),
      .value (value_ff),
      .res   (cmp_res)
   );

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;

   // insert stops at the first entry not smaller, delete at the first equal one
   assign hit     = (kind_ff == KIND_DELETE) ? cmp_res.eq : cmp_res.ge;
   assign idx_dec = idx_ff - 1'b1;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      pos_in      = pos_ff;
      wa_in       = wa_ff;
      status_in   = status_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wa_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[AW-1:0];
      rsp_load    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               idx_in  = '0;
               pend_in = 1'b0;
               if ((req_if.kind == KIND_INSERT) && (count_ff == CAP_CNT)) begin
                  // store full: refuse, just report
                  status_in = STATUS_FULL;
                  pos_in    = '0;
                  state_in  = S_HEAD;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // read issued last cycle is compared this cycle
            if (pend_ff && hit) begin
               pend_in   = 1'b0;
               pos_in    = idx_dec;
               status_in = STATUS_DONE;
               // insert shifts from the top down, delete from just past the hit
               idx_in    = (kind_ff == KIND_INSERT) ? count_ff : idx_ff;
               state_in  = S_SHIFT;
            end else if (idx_ff == count_ff) begin
               pend_in = 1'b0;
               if (kind_ff == KIND_INSERT) begin
                  // append at the end
                  pos_in    = count_ff;
                  status_in = STATUS_DONE;
                  idx_in    = count_ff;
                  state_in  = S_SHIFT;
               end else begin
                  pos_in    = '0;
                  status_in = STATUS_NOT_FOUND;
                  state_in  = S_HEAD;
               end
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff[AW-1:0];
               idx_in      = idx_ff + 1'b1;
               pend_in     = 1'b1;
            end
         end
         S_SHIFT: begin
            // write back the word read last cycle, one slot over
            ram_wr_en = pend_ff;
            if (kind_ff == KIND_INSERT) begin
               if (idx_ff > pos_ff) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_dec[AW-1:0];
                  wa_in       = idx_ff[AW-1:0];
                  idx_in      = idx_dec;
                  pend_in     = 1'b1;
               end else begin
                  pend_in  = 1'b0;
                  state_in = S_PUT;
               end
            end else begin
               if (idx_ff < count_ff) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_ff[AW-1:0];
                  wa_in       = idx_dec[AW-1:0];
                  idx_in      = idx_ff + 1'b1;
                  pend_in     = 1'b1;
               end else begin
                  pend_in  = 1'b0;
                  count_in = count_ff - 1'b1;
                  state_in = S_HEAD;
               end
            end
         end
         S_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[AW-1:0];
            ram_wr_data = value_ff;
            count_in    = count_ff + 1'b1;
            state_in    = S_HEAD;
         end
         S_HEAD: begin
            // fetch entry 0 for the smallest value
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            state_in    = S_WAIT;
         end
         S_WAIT: begin
            // ram output holds entry 0 until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign pos_wide   = {{POS_W{1'b0}}, pos_ff};
   assign count_wide = {{COUNT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_if.kind;
         value_ff <= req_if.value;
      end
      pos_ff    <= pos_in;
      wa_ff     <= wa_in;
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_status_ff   <= status_ff;
         rsp_position_ff <= pos_wide[POS_W-1:0];
         rsp_count_ff    <= count_wide[COUNT_W-1:0];
         rsp_empty_ff    <= (count_ff == '0);
         rsp_smallest_ff <= (count_ff == '0) ? '0 : ram_rd_data;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.position       = rsp_position_ff;
   assign rsp_if.entry_count    = rsp_count_ff;
   assign rsp_if.is_empty       = rsp_empty_ff;
   assign rsp_if.smallest_value = rsp_smallest_ff;

   // checks

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_SHIFT || state_ff == S_PUT))
      else $error("ram written outside shift or put");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_SCAN || state_ff == S_HEAD))
      else $error("accepted command did not start");

   a_empty_smallest: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.is_empty) |->
         (rsp_if.smallest_value == '0 && rsp_if.entry_count == '0))
      else $error("empty result with nonzero smallest value or count");

endmodule
